>>> sv/keypad_scan_blink_code_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keypad scan blink code unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_BLINK_CODE_UNIT_DEFINES_SVH
`define KEYPAD_SCAN_BLINK_CODE_UNIT_DEFINES_SVH

// hold a condition at every clock edge
`define KSCB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// imply a consequence in the same cycle
`define KSCB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/kscb_pkg.sv
// ----------------------------------------------------------------------------
// kscb_pkg
// Shared widths, defaults and types of the keypad scan blink code unit.
// ----------------------------------------------------------------------------
package kscb_pkg;

    localparam int COL_W         = 3;
    localparam int ROW_DRIVE_W   = 4;
    localparam int UNIT_W        = 20;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int ROWS_DEFAULT  = 4;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = UNIT_W'(1000);

    localparam logic [COL_W-1:0] COLS_NONE = 3'b111;
    localparam logic [COL_W-1:0] COLS_ONE  = 3'b011;
    localparam logic [COL_W-1:0] COLS_TWO  = 3'b101;
    localparam logic [COL_W-1:0] COLS_THREE = 3'b110;

    localparam logic [0:0] REG_UNIT_TICKS = 1'b0;

    typedef struct packed {
        logic [ROW_DRIVE_W-1:0] row_drive;
        logic                   led_off;
        logic                   busy_res;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t res;
    } push_t;

endpackage

>>> sv/kscb_if.sv
// ----------------------------------------------------------------------------
// kscb_sense_if / kscb_result_if
// Valid/ready channels for column sense ticks and scan results.
// ----------------------------------------------------------------------------
interface kscb_sense_if;
    import kscb_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] col_sense;

    modport source (output valid, output col_sense, input ready);
    modport sink   (input valid, input col_sense, output ready);
endinterface

interface kscb_result_if;
    import kscb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ROW_DRIVE_W-1:0] row_drive;
    logic                   led_off;
    logic                   busy_res;

    modport source (output valid, output row_drive, output led_off, output busy_res,
                    input ready);
    modport sink   (input valid, input row_drive, input led_off, input busy_res,
                    output ready);
endinterface

>>> sv/keypad_scan_blink_code_unit.sv
// ----------------------------------------------------------------------------
// keypad_scan_blink_code_unit
// Matrix keypad row scanner that plays the pressed key as an LED blink code.
// ----------------------------------------------------------------------------
// Usage:
//   sense carries one transaction per clock tick: the three active-low column
//   bits read under the row drive of the previous result. result returns one
//   transaction per sense transaction: row_drive, led_off and busy_res as the
//   pin levels after that tick. The APB port holds unit_ticks at address 0;
//   write it only while the block is idle.
//   Path: a sense transaction is registered, then evaluated into the
//   result queue, which offers it to the receiver until it is taken.
//   Throughput: one transaction per cycle while the result queue has
//   space, set by the update of the sequencer state between the input
//   register and the result queue.
//   Reset: row zero driven, scanner armed, no code playing, unit_ticks 1000.
//   Receiver stall: the two-entry result queue fills, the input register
//   holds the next tick, then sense.ready drops and the sequencer holds its
//   state until a result is taken.
// ----------------------------------------------------------------------------
`include "keypad_scan_blink_code_unit_defines.svh"

module keypad_scan_blink_code_unit #(
    parameter int ROWS = kscb_pkg::ROWS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kscb_pkg::ADDR_W-1:0] paddr,
    input  logic [kscb_pkg::DATA_W-1:0] pwdata,
    output logic [kscb_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    kscb_sense_if.sink                  sense,
    kscb_result_if.source               result
);
    import kscb_pkg::*;

    logic [UNIT_W-1:0] unit_ticks;
    push_t             push;
    logic              space;

    kscb_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .unit_ticks (unit_ticks)
    );

    kscb_core #(
        .ROWS (ROWS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_ticks (unit_ticks),
        .sense      (sense),
        .space      (space),
        .push       (push)
    );

    kscb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .result (result)
    );

    `KSCB_ASSERT_IMPLY(a_idle_led_dark, result.valid && !result.busy_res, result.led_off, "LED lit while no code plays")
    `KSCB_ASSERT_IMPLY(a_row_onehot, result.valid, $onehot(~result.row_drive) || (result.row_drive == 4'hF), "row drive not one-hot low")
    `KSCB_ASSERT_IMPLY(a_stall_has_result, !sense.ready, result.valid, "input stalled with no pending result")

endmodule

>>> sv/kscb_cfg.sv
// ----------------------------------------------------------------------------
// kscb_cfg
// APB register port holding the blink unit length in ticks.
// ----------------------------------------------------------------------------
module kscb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kscb_pkg::ADDR_W-1:0] paddr,
    input  logic [kscb_pkg::DATA_W-1:0] pwdata,
    output logic [kscb_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [kscb_pkg::UNIT_W-1:0] unit_ticks
);
    import kscb_pkg::*;

    logic [UNIT_W-1:0] unit_ticks_reg;
    logic              wr_en;
    logic [0:0]        reg_index;

    assign reg_index = paddr[ADDR_W-1 -: 1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready
                       && (reg_index == REG_UNIT_TICKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end
        else if (wr_en)
        begin
            unit_ticks_reg <= pwdata[UNIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_UNIT_TICKS)
        begin
            prdata = DATA_W'(unit_ticks_reg);
        end
    end

    assign unit_ticks = unit_ticks_reg;

endmodule

>>> sv/kscb_core.sv
// ----------------------------------------------------------------------------
// kscb_core
// Input register, scan and blink sequencer state, next result per tick.
// ----------------------------------------------------------------------------
module kscb_core #(
    parameter int ROWS = kscb_pkg::ROWS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [kscb_pkg::UNIT_W-1:0] unit_ticks,
    kscb_sense_if.sink                  sense,
    input  logic                        space,
    output kscb_pkg::push_t             push
);
    import kscb_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int BL_W  = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ROW   = 2'd1,
        PH_PAUSE = 2'd2,
        PH_COL   = 2'd3
    } phase_t;

    logic             in_valid_reg;
    logic [COL_W-1:0] in_cols_reg;

    logic [ROW_W-1:0]  row_reg,    row_next;
    logic              armed_reg,  armed_next;
    phase_t            phase_reg,  phase_next;
    logic [BL_W-1:0]   blinks_reg, blinks_next;
    logic [1:0]        colnum_reg, colnum_next;
    logic              lit_reg,    lit_next;
    logic [UNIT_W-1:0] timer_reg,  timer_next;

    logic              advance;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] timer_inc;
    logic [BL_W-1:0]   blinks_dec;
    logic [1:0]        col_code;
    logic [3:0]        row_ext;

    assign advance     = in_valid_reg && space;
    assign sense.ready = !in_valid_reg || space;

    assign unit       = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
    assign timer_inc  = timer_reg + UNIT_W'(1);
    assign blinks_dec = (blinks_reg != '0) ? blinks_reg - BL_W'(1) : '0;

    always_comb
    begin
        case (in_cols_reg)
            COLS_ONE:   col_code = 2'd1;
            COLS_TWO:   col_code = 2'd2;
            COLS_THREE: col_code = 2'd3;
            default:    col_code = 2'd0;
        endcase
    end

    always_comb
    begin
        row_next    = row_reg;
        armed_next  = armed_reg;
        phase_next  = phase_reg;
        blinks_next = blinks_reg;
        colnum_next = colnum_reg;
        lit_next    = lit_reg;
        timer_next  = timer_reg;

        if (phase_reg != PH_IDLE)
        begin
            timer_next = timer_inc;
            if (timer_inc >= unit)
            begin
                timer_next = '0;
                case (phase_reg)
                    PH_ROW, PH_COL:
                    begin
                        if (lit_reg)
                        begin
                            lit_next = 1'b0;
                        end
                        else
                        begin
                            blinks_next = blinks_dec;
                            if (blinks_dec != '0)
                            begin
                                lit_next = 1'b1;
                            end
                            else if (phase_reg == PH_ROW)
                            begin
                                phase_next  = PH_PAUSE;
                                blinks_next = BL_W'(2);
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_PAUSE:
                    begin
                        blinks_next = blinks_dec;
                        if (blinks_dec == '0)
                        begin
                            phase_next  = PH_COL;
                            blinks_next = BL_W'(colnum_reg);
                            lit_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (in_cols_reg == COLS_NONE)
        begin
            row_next   = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
            armed_next = 1'b1;
        end
        else if (armed_reg)
        begin
            armed_next = 1'b0;
            if (col_code != 2'd0)
            begin
                colnum_next = col_code;
                phase_next  = PH_ROW;
                blinks_next = BL_W'(row_reg) + BL_W'(1);
                lit_next    = 1'b1;
                timer_next  = '0;
            end
        end
    end

    assign row_ext = 4'(row_next);

    always_comb
    begin
        push.push = advance;
        for (int i = 0; i < ROW_DRIVE_W; i++)
        begin
            push.res.row_drive[i] = (row_ext != 4'(i));
        end
        push.res.led_off  = !((phase_next != PH_IDLE) && lit_next);
        push.res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_cols_reg  <= COLS_NONE;
            row_reg      <= '0;
            armed_reg    <= 1'b1;
            phase_reg    <= PH_IDLE;
            blinks_reg   <= '0;
            colnum_reg   <= '0;
            lit_reg      <= 1'b0;
            timer_reg    <= '0;
        end
        else
        begin
            if (sense.valid && sense.ready)
            begin
                in_valid_reg <= 1'b1;
                in_cols_reg  <= sense.col_sense;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                row_reg    <= row_next;
                armed_reg  <= armed_next;
                phase_reg  <= phase_next;
                blinks_reg <= blinks_next;
                colnum_reg <= colnum_next;
                lit_reg    <= lit_next;
                timer_reg  <= timer_next;
            end
        end
    end

endmodule

>>> sv/kscb_queue.sv
// ----------------------------------------------------------------------------
// kscb_queue
// Two-entry result register that decouples the sequencer from the receiver.
// ----------------------------------------------------------------------------
module kscb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  kscb_pkg::push_t push,
    output logic            space,
    kscb_result_if.source   result
);
    import kscb_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;
    result_t    head;

    assign space = (count_reg != 2'd2);
    assign pop   = result.valid && result.ready;
    assign head  = mem[rd_ptr_reg];

    assign result.valid     = (count_reg != 2'd0);
    assign result.row_drive = head.row_drive;
    assign result.led_off   = head.led_off;
    assign result.busy_res  = head.busy_res;

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[wr_ptr_reg] <= push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push.push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
